// ----- rtl/core/ppm_pkg.sv -----
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants for the pedal plausibility monitor.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int ADC_BITS_DEF    = 12;
    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int CODE_W      = 12;
    localparam int SPEED_W     = 16;
    localparam int DT_W        = 16;
    localparam int Q16_W       = 17;
    localparam int QUOT_W      = 17;
    localparam int POS_S_W     = 18;
    localparam int SUM_W       = 19;
    localparam int ELAPSED_W   = 24;
    localparam int LEVEL_W     = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;

    // pos = round(NUM * code / (DEN * FS)) - POS_OFFSET
    localparam int unsigned SCALE_A_NUM = 540672;
    localparam int unsigned SCALE_A_DEN = 5;
    localparam int unsigned SCALE_B_NUM = 90112;
    localparam int unsigned SCALE_B_DEN = 1;

    localparam logic signed [POS_S_W-1:0] POS_OFFSET = 18'sd8192;
    localparam logic [Q16_W-1:0]          Q16_ONE    = 17'd65536;
    localparam logic [ELAPSED_W-1:0]      ELAPSED_MAX = 24'hFFFFFF;

    localparam logic [ELAPSED_W-1:0] HOLD_TIME_RST     = 24'd100000;
    localparam logic [LEVEL_W-1:0]   BRAKE_HIGH_RST    = 17'd58982;
    localparam logic [LEVEL_W-1:0]   THROTTLE_HIGH_RST = 17'd52429;
    localparam logic [LEVEL_W-1:0]   START_BRAKE_RST   = 17'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_TIME     = 2'd0,
        REG_BRAKE_HIGH    = 2'd1,
        REG_THROTTLE_HIGH = 2'd2,
        REG_START_BRAKE   = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_WAIT_BRAKE   = 2'd0,
        PH_WAIT_COCKPIT = 2'd1,
        PH_RUN          = 2'd2
    } phase_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] hold_time_us;
        logic [LEVEL_W-1:0]   brake_high_level;
        logic [LEVEL_W-1:0]   throttle_high_level;
        logic [LEVEL_W-1:0]   start_brake_level;
    } cfg_t;

    // sample fields that ride along the scaling pipeline
    typedef struct packed {
        logic               cockpit_on;
        logic [SPEED_W-1:0] speed_front;
        logic [SPEED_W-1:0] speed_rear;
        logic [DT_W-1:0]    delta_us;
    } side_t;

    // classified item handed from front to back
    typedef struct packed {
        logic             start_pass;
        logic             cockpit_on;
        logic             pedal_flag;
        logic             traction_flag;
        logic [Q16_W-1:0] avg_q16;
        logic [DT_W-1:0]  delta_us;
    } item_t;

    typedef struct packed {
        logic             traction_fault;
        logic             traction_flag;
        logic             pedal_fault;
        logic             pedal_flag;
        logic [1:0]       phase_now;
        logic [Q16_W-1:0] throttle_q16;
    } result_t;

endpackage

// ----- rtl/core/ppm_scale.sv -----
// ----------------------------------------------------------------------------
// ppm_scale
// Three-stage constant divider: ADC code to offset Q16 position, rounded.
// ----------------------------------------------------------------------------
module ppm_scale
    import ppm_pkg::*;
#(
    parameter int          ADC_BITS = ADC_BITS_DEF,
    parameter int unsigned KNUM     = SCALE_A_NUM,
    parameter int unsigned KDEN     = SCALE_A_DEN
)
(
    input  logic              clk,
    input  logic [CODE_W-1:0] code,
    output logic [QUOT_W-1:0] quot
);

    localparam longint unsigned FS      = (64'd1 << ADC_BITS) - 64'd1;
    localparam int              SHIFT   = ADC_BITS + 1;
    localparam longint unsigned RECIP_L = (longint'(KNUM) << SHIFT) / (longint'(KDEN) * FS);
    localparam int              RECIP_W = $clog2(RECIP_L + 1);
    localparam int              PROD_W  = ADC_BITS + RECIP_W;
    localparam int              CMP_W   = ADC_BITS + 22;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam logic [PROD_W:0]    HALF  = (PROD_W + 1)'(64'd1 << (SHIFT - 1));
    localparam logic [CMP_W-1:0]   NUM2  = CMP_W'(2 * longint'(KNUM));
    localparam logic [CMP_W-1:0]   DEN1  = CMP_W'(longint'(KDEN) * FS);
    localparam logic [CMP_W-1:0]   DEN2  = CMP_W'(2 * longint'(KDEN) * FS);

    logic [CODE_W+ADC_BITS-1:0] code_ext;
    logic [ADC_BITS-1:0]        c;
    logic [PROD_W-1:0]          prod_reg;
    logic [ADC_BITS-1:0]        code1_reg;
    logic [PROD_W:0]            qsum;
    logic [QUOT_W-1:0]          qest_reg;
    logic [CMP_W-1:0]           lhs_reg;
    logic [QUOT_W-1:0]          qinc;
    logic [CMP_W-1:0]           rhs;
    logic                       fits;
    logic [QUOT_W-1:0]          quot_reg;

    // code masked to ADC_BITS
    assign code_ext = {{ADC_BITS{1'b0}}, code};
    assign c        = code_ext[ADC_BITS-1:0];

    // reciprocal estimate is exact or one low; stage three fixes it
    assign qsum = {1'b0, prod_reg} + HALF;
    assign qinc = qest_reg + 1'b1;
    assign rhs  = CMP_W'(qinc) * DEN2;
    assign fits = (rhs <= lhs_reg);

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(c) * PROD_W'(RECIP);
        code1_reg <= c;
        qest_reg  <= qsum[SHIFT +: QUOT_W];
        lhs_reg   <= CMP_W'(code1_reg) * NUM2 + DEN1;
        quot_reg  <= fits ? qinc : qest_reg;
    end

    assign quot = quot_reg;

endmodule

// ----- rtl/core/ppm_front.sv -----
// ----------------------------------------------------------------------------
// ppm_front
// Input side: accepts samples, scales sensors, computes instant flags.
// ----------------------------------------------------------------------------
module ppm_front
    import ppm_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF,
    parameter int DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // pedal_a_code, pedal_b_code, brake_code, cockpit_on, speed_front,
    // speed_rear, delta_us, zero pad
    input  logic [IN_TDATA_W-1:0]        s_tdata,
    input  cfg_t                         cfg,
    input  logic [$clog2(DEPTH+1)-1:0]   fifo_count,
    output logic                         push,
    output item_t                        item
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic [2:0]        v_reg;
    side_t             side_reg [3];
    side_t             side_in;
    logic [CNT_W:0]    credit;
    logic [QUOT_W-1:0] qa, qb, qbr;

    logic signed [POS_S_W-1:0] pa, pb, br;
    logic signed [SUM_W-1:0]   sum, diff;
    logic [SUM_W-1:0]          diff_abs;
    logic [POS_S_W-1:0]        gap;
    logic [22:0]               gap20;
    logic signed [23:0]        gap20_s, sum_s24;
    logic signed [19:0]        br_s20, sum_s20, brake_hi_s20, thr2_s20, start_s20;
    logic signed [POS_S_W-1:0] one_s;
    logic                      out_of_range, hard_brake, pflag;
    logic [SUM_W-2:0]          half;
    logic [Q16_W-1:0]          avg;
    logic [SPEED_W-1:0]        sf, sr, wgap;
    logic [20:0]               wgap20;
    logic [SPEED_W:0]          wsum;

    // room in the queue for every item already in the pipe
    assign credit   = (CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(v_reg[0])
                    + (CNT_W + 1)'(v_reg[1]) + (CNT_W + 1)'(v_reg[2]);
    assign s_tready = (credit < (CNT_W + 1)'(DEPTH));
    assign accept   = s_tvalid && s_tready;

    assign side_in.cockpit_on  = s_tdata[36];
    assign side_in.speed_front = s_tdata[52:37];
    assign side_in.speed_rear  = s_tdata[68:53];
    assign side_in.delta_us    = s_tdata[84:69];

    ppm_scale #(.ADC_BITS(ADC_BITS), .KNUM(SCALE_A_NUM), .KDEN(SCALE_A_DEN)) u_scale_a
    (
        .clk  (clk),
        .code (s_tdata[11:0]),
        .quot (qa)
    );

    ppm_scale #(.ADC_BITS(ADC_BITS), .KNUM(SCALE_B_NUM), .KDEN(SCALE_B_DEN)) u_scale_b
    (
        .clk  (clk),
        .code (s_tdata[23:12]),
        .quot (qb)
    );

    ppm_scale #(.ADC_BITS(ADC_BITS), .KNUM(SCALE_A_NUM), .KDEN(SCALE_A_DEN)) u_scale_br
    (
        .clk  (clk),
        .code (s_tdata[35:24]),
        .quot (qbr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 3'b000;
        end
        else
        begin
            v_reg <= {v_reg[1:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_in;
        side_reg[1] <= side_reg[0];
        side_reg[2] <= side_reg[1];
    end

    // pedal checks
    assign pa = $signed({1'b0, qa})  - POS_OFFSET;
    assign pb = $signed({1'b0, qb})  - POS_OFFSET;
    assign br = $signed({1'b0, qbr}) - POS_OFFSET;

    assign sum      = {pa[POS_S_W-1], pa} + {pb[POS_S_W-1], pb};
    assign diff     = {pa[POS_S_W-1], pa} - {pb[POS_S_W-1], pb};
    assign diff_abs = diff[SUM_W-1] ? (~diff + 1'b1) : diff;
    assign gap      = diff_abs[POS_S_W-1:0];
    assign gap20    = 23'(gap) * 23'd20;
    assign gap20_s  = $signed({1'b0, gap20});
    assign sum_s24  = {{5{sum[SUM_W-1]}}, sum};

    assign one_s        = $signed({1'b0, Q16_ONE});
    assign out_of_range = pa[POS_S_W-1] || (pa > one_s) || pb[POS_S_W-1] || (pb > one_s);

    assign br_s20       = {{2{br[POS_S_W-1]}}, br};
    assign sum_s20      = {sum[SUM_W-1], sum};
    assign brake_hi_s20 = $signed({3'b000, cfg.brake_high_level});
    assign thr2_s20     = $signed({2'b00, cfg.throttle_high_level, 1'b0});
    assign start_s20    = $signed({3'b000, cfg.start_brake_level});
    assign hard_brake   = (br_s20 > brake_hi_s20) && (sum_s20 > thr2_s20);

    assign pflag = (gap20_s > sum_s24) || out_of_range || hard_brake;

    // throttle: clamped pedal average
    assign half = sum[SUM_W-1:1];
    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            avg = '0;
        end
        else if (half > (SUM_W - 1)'(Q16_ONE))
        begin
            avg = Q16_ONE;
        end
        else
        begin
            avg = half[Q16_W-1:0];
        end
    end

    // wheel speed check
    assign sf     = side_reg[2].speed_front;
    assign sr     = side_reg[2].speed_rear;
    assign wgap   = (sf > sr) ? (sf - sr) : (sr - sf);
    assign wgap20 = 21'(wgap) * 21'd20;
    assign wsum   = {1'b0, sf} + {1'b0, sr};

    assign item.start_pass    = (br_s20 > start_s20);
    assign item.cockpit_on    = side_reg[2].cockpit_on;
    assign item.pedal_flag    = pflag;
    assign item.traction_flag = (wgap20 > {4'b0000, wsum});
    assign item.avg_q16       = avg;
    assign item.delta_us      = side_reg[2].delta_us;

    assign push = v_reg[2];

endmodule

// ----- rtl/core/ppm_fifo.sv -----
// ----------------------------------------------------------------------------
// ppm_fifo
// Short queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module ppm_fifo
    import ppm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      wr_data,
    input  logic                       pop,
    output item_t                      rd_data,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             store [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = store[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ----- rtl/core/ppm_persist.sv -----
// ----------------------------------------------------------------------------
// ppm_persist
// Persistence timer: latches a fault once its flag has held for the hold time.
// ----------------------------------------------------------------------------
module ppm_persist
    import ppm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 flag,
    input  logic [DT_W-1:0]      dt,
    input  logic [ELAPSED_W-1:0] hold,
    output logic                 latched_next
);

    logic                 on_reg, on_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 latched_reg;
    logic [ELAPSED_W:0]   e_sum;
    logic [ELAPSED_W-1:0] e_adv;

    assign e_sum = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(dt);

    always_comb
    begin
        if (on_reg)
        begin
            e_adv = e_sum[ELAPSED_W] ? ELAPSED_MAX : e_sum[ELAPSED_W-1:0];
        end
        else
        begin
            e_adv = elapsed_reg;
        end
    end

    always_comb
    begin
        on_next      = on_reg;
        elapsed_next = elapsed_reg;
        latched_next = latched_reg;
        if (step)
        begin
            elapsed_next = e_adv;
            priority if (flag && !on_reg)
            begin
                on_next      = 1'b1;
                elapsed_next = '0;
            end
            else if (flag && (e_adv >= hold))
            begin
                latched_next = 1'b1;
            end
            else if (!flag && on_reg)
            begin
                latched_next = 1'b0;
                on_next      = 1'b0;
                elapsed_next = '0;
            end
            else
            begin
                // flag held below the hold time: only the count moves; idle: nothing moves
                elapsed_next = e_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg      <= 1'b0;
            elapsed_reg <= '0;
            latched_reg <= 1'b0;
        end
        else
        begin
            on_reg      <= on_next;
            elapsed_reg <= elapsed_next;
            latched_reg <= latched_next;
        end
    end

endmodule

// ----- rtl/core/ppm_back.sv -----
// ----------------------------------------------------------------------------
// ppm_back
// Back end: start-up phase sequencer, fault timers and output register.
// ----------------------------------------------------------------------------
module ppm_back
    import ppm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ELAPSED_W-1:0]   hold_time_us,
    input  item_t                  item,
    input  logic                   item_valid,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // throttle_q16, phase_now, pedal_flag, pedal_fault, traction_flag,
    // traction_fault, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    phase_t  phase_reg, phase_next;
    logic    running;
    logic    step;
    logic    pl_next, wl_next;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;

    assign pop  = item_valid && (!out_valid_reg || m_tready);
    assign step = pop && running;

    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            unique case (phase_reg)
                PH_WAIT_BRAKE:
                begin
                    if (item.start_pass)
                    begin
                        phase_next = PH_WAIT_COCKPIT;
                    end
                end
                PH_WAIT_COCKPIT:
                begin
                    if (item.cockpit_on)
                    begin
                        phase_next = PH_RUN;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_WAIT_BRAKE:   running = 1'b0;
            PH_WAIT_COCKPIT: running = 1'b0;
            default:         running = 1'b1;
        endcase
    end

    ppm_persist u_pedal_timer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .flag         (item.pedal_flag),
        .dt           (item.delta_us),
        .hold         (hold_time_us),
        .latched_next (pl_next)
    );

    ppm_persist u_wheel_timer
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .flag         (item.traction_flag),
        .dt           (item.delta_us),
        .hold         (hold_time_us),
        .latched_next (wl_next)
    );

    always_comb
    begin
        result.throttle_q16   = (running && !pl_next && !wl_next) ? item.avg_q16 : '0;
        result.phase_now      = phase_next;
        result.pedal_flag     = running && item.pedal_flag;
        result.pedal_fault    = pl_next;
        result.traction_flag  = running && item.traction_flag;
        result.traction_fault = wl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_BRAKE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

// ----- rtl/core/pedal_plausibility_monitor.sv -----
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor
// Accelerator pedal plausibility, brake and wheel-speed check with throttle.
// ----------------------------------------------------------------------------
// Samples come in on the s_ stream, one per item; one result per sample goes
// out on the m_ stream in the same order. Thresholds are set through the
// wr_en / wr_index / wr_data port; the user is to write them only while the
// block is idle, which the block itself does not enforce.
// Throughput: one item per cycle while the receiver takes results and the
// queue has room, set by the per-item update of the phase and persistence
// timer registers in the back end. A result passes three scaling stages,
// one queue slot, then the output register before it shows on m_tvalid.
// Reset: thresholds return to their defaults, the phase goes back to waiting
// for the brake, both timers and faults clear, the queue empties; s_tready
// comes up right away.
// Receiver stall: the result holds on m_tdata, the queue keeps filling and
// s_tready drops once the queue plus items in the scaling pipe reach
// QUEUE_DEPTH.
// ----------------------------------------------------------------------------
module pedal_plausibility_monitor
    import ppm_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pedal_a_code[11:0], pedal_b_code[23:12], brake_code[35:24],
    // cockpit_on[36], speed_front[52:37], speed_rear[68:53],
    // delta_us[84:69], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // throttle_q16[16:0], phase_now[18:17], pedal_flag[19], pedal_fault[20],
    // traction_flag[21], traction_fault[22], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cfg_t             cfg_reg;
    cfg_idx_t         wr_sel;
    logic             push, pop, not_empty;
    item_t            wr_item, rd_item;
    logic [CNT_W-1:0] fifo_count;

    assign wr_sel = cfg_idx_t'(wr_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_us        <= HOLD_TIME_RST;
            cfg_reg.brake_high_level    <= BRAKE_HIGH_RST;
            cfg_reg.throttle_high_level <= THROTTLE_HIGH_RST;
            cfg_reg.start_brake_level   <= START_BRAKE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_sel)
                REG_HOLD_TIME:     cfg_reg.hold_time_us        <= wr_data;
                REG_BRAKE_HIGH:    cfg_reg.brake_high_level    <= wr_data[LEVEL_W-1:0];
                REG_THROTTLE_HIGH: cfg_reg.throttle_high_level <= wr_data[LEVEL_W-1:0];
                REG_START_BRAKE:   cfg_reg.start_brake_level   <= wr_data[LEVEL_W-1:0];
            endcase
        end
    end

    ppm_front #(.ADC_BITS(ADC_BITS), .DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .fifo_count (fifo_count),
        .push       (push),
        .item       (wr_item)
    );

    ppm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_item),
        .pop       (pop),
        .rd_data   (rd_item),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    ppm_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .hold_time_us (cfg_reg.hold_time_us),
        .item         (rd_item),
        .item_valid   (not_empty),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ----- test/pedal_plausibility_monitor_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor_tb
// Self-checking bench for the pedal plausibility monitor.
// ----------------------------------------------------------------------------
// Samples are streamed in under random sender gaps and receiver stalls. Each
// accepted sample runs through an in-bench model of the start sequence,
// sensor scaling and the two fault timers, and the predicted result is
// queued. Results coming out are compared field by field, in order. A short
// table of hand-picked samples goes first, then random episodes of clean and
// faulty samples under several threshold settings.
// ----------------------------------------------------------------------------
module pedal_plausibility_monitor_tb;
    import ppm_pkg::*;

    localparam int     LIMIT_CYCLES  = 200000;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     LONG_HOLD     = 60;
    localparam longint FULL_SCALE    = (longint'(1) << ADC_BITS_DEF) - 1;

    typedef struct packed {
        logic [DT_W-1:0]    delta_us;
        logic [SPEED_W-1:0] speed_rear;
        logic [SPEED_W-1:0] speed_front;
        logic               cockpit_on;
        logic [CODE_W-1:0]  brake_code;
        logic [CODE_W-1:0]  pedal_b_code;
        logic [CODE_W-1:0]  pedal_a_code;
    } sample_t;

    typedef struct packed {
        logic                 running;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 latched;
    } hold_timer_t;

    typedef struct packed {
        logic    known;
        result_t res;
        sample_t smp;
    } dir_row_t;

    typedef enum int {
        EP_CLEAN,
        EP_PEDAL_BAD,
        EP_WHEEL_BAD,
        EP_BOTH_BAD,
        EP_NOISE
    } episode_t;

    localparam result_t NO_RESULT = '0;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   wr_en;
    logic [CFG_IDX_W-1:0]   wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    // shadow thresholds and monitor state
    logic [ELAPSED_W-1:0] hold_us;
    logic [LEVEL_W-1:0]   brake_high;
    logic [LEVEL_W-1:0]   throttle_high;
    logic [LEVEL_W-1:0]   start_brake;
    logic [1:0]           ph_state;
    hold_timer_t          pedal_tmr;
    hold_timer_t          wheel_tmr;

    result_t  outputs_due[$];
    dir_row_t dir_table[$];
    int       mismatch_count;
    int       results_seen;
    int       cycle_count;
    bit       tx_idle_on;
    bit       rx_idle_on;
    bit       long_hold_req;

    pedal_plausibility_monitor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // rounds to nearest, ties toward +inf
    function automatic longint round_quot(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r < 0)
        begin
            q = q - 1;
            r = r + d;
        end
        if (2 * r >= d)
            q = q + 1;
        return q;
    endfunction

    function automatic longint pos_sensor_a(logic [CODE_W-1:0] code);
        return round_quot(4096 * (132 * longint'(code) - 10 * FULL_SCALE), 5 * FULL_SCALE);
    endfunction

    function automatic longint pos_sensor_b(logic [CODE_W-1:0] code);
        return round_quot(8192 * (33 * longint'(code) - 3 * FULL_SCALE), 3 * FULL_SCALE);
    endfunction

    function automatic hold_timer_t step_timer(hold_timer_t t, logic flag, logic [DT_W-1:0] dt);
        logic [ELAPSED_W:0] total;
        if (t.running)
        begin
            total = {1'b0, t.elapsed} + (ELAPSED_W + 1)'(dt);
            t.elapsed = (total > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : total[ELAPSED_W-1:0];
        end
        if (flag && !t.running)
        begin
            t.running = 1'b1;
            t.elapsed = '0;
        end
        else if (flag && t.elapsed >= hold_us)
            t.latched = 1'b1;
        else if (!flag && t.running)
        begin
            t.latched = 1'b0;
            t.running = 1'b0;
            t.elapsed = '0;
        end
        return t;
    endfunction

    // advances the shadow state by one sample and returns its result
    function automatic result_t next_output(sample_t s);
        result_t o;
        longint  pa;
        longint  pb;
        longint  br;
        longint  sum;
        longint  gap;
        longint  f;
        longint  r;
        longint  wgap;
        longint  avg;
        logic    pflag;
        logic    wflag;
        o = '0;
        pflag = 1'b0;
        wflag = 1'b0;
        case (ph_state)
            PH_WAIT_BRAKE:
                if (pos_sensor_a(s.brake_code) > longint'(start_brake))
                    ph_state = PH_WAIT_COCKPIT;
            PH_WAIT_COCKPIT:
                if (s.cockpit_on)
                    ph_state = PH_RUN;
            default:
            begin
                pa = pos_sensor_a(s.pedal_a_code);
                pb = pos_sensor_b(s.pedal_b_code);
                br = pos_sensor_a(s.brake_code);
                sum = pa + pb;
                gap = (pa > pb) ? pa - pb : pb - pa;
                f = longint'(s.speed_front);
                r = longint'(s.speed_rear);
                wgap = (f > r) ? f - r : r - f;
                pflag = (20 * gap > sum);
                if (pa < 0 || pa > longint'(Q16_ONE) || pb < 0 || pb > longint'(Q16_ONE))
                    pflag = 1'b1;
                if (br > longint'(brake_high) && sum > 2 * longint'(throttle_high))
                    pflag = 1'b1;
                pedal_tmr = step_timer(pedal_tmr, pflag, s.delta_us);
                wflag = (20 * wgap > f + r);
                wheel_tmr = step_timer(wheel_tmr, wflag, s.delta_us);
                avg = (sum < 0) ? 0 : sum / 2;
                if (avg > longint'(Q16_ONE))
                    avg = longint'(Q16_ONE);
                if (!pedal_tmr.latched && !wheel_tmr.latched)
                    o.throttle_q16 = avg[Q16_W-1:0];
            end
        endcase
        o.phase_now = ph_state;
        o.pedal_flag = pflag;
        o.pedal_fault = pedal_tmr.latched;
        o.traction_flag = wflag;
        o.traction_fault = wheel_tmr.latched;
        return o;
    endfunction

    function automatic sample_t smp(int a, int b, int br, int ck, int f, int r, int dt);
        sample_t s;
        s.pedal_a_code = a[CODE_W-1:0];
        s.pedal_b_code = b[CODE_W-1:0];
        s.brake_code = br[CODE_W-1:0];
        s.cockpit_on = ck[0];
        s.speed_front = f[SPEED_W-1:0];
        s.speed_rear = r[SPEED_W-1:0];
        s.delta_us = dt[DT_W-1:0];
        return s;
    endfunction

    function automatic result_t res(int thr, logic [1:0] ph, bit pfl, bit pft, bit tfl, bit tft);
        result_t o;
        o.throttle_q16 = thr[Q16_W-1:0];
        o.phase_now = ph;
        o.pedal_flag = pfl;
        o.pedal_fault = pft;
        o.traction_flag = tfl;
        o.traction_fault = tft;
        return o;
    endfunction

    function automatic logic [CODE_W-1:0] to_code(longint v);
        if (v < 0)
            return '0;
        if (v > FULL_SCALE)
            return FULL_SCALE[CODE_W-1:0];
        return v[CODE_W-1:0];
    endfunction

    // clean samples track one pedal position on both sensors and close wheel speeds
    function automatic sample_t make_sample(episode_t kind);
        sample_t          s;
        longint           p;
        logic [SPEED_W-1:0] swap;
        s.pedal_a_code = CODE_W'($urandom_range(0, 4095));
        s.pedal_b_code = CODE_W'($urandom_range(0, 4095));
        s.brake_code = CODE_W'($urandom_range(0, 4095));
        s.cockpit_on = 1'($urandom_range(0, 1));
        s.speed_front = SPEED_W'($urandom_range(0, 65535));
        s.speed_rear = SPEED_W'($urandom_range(0, 65535));
        s.delta_us = DT_W'($urandom_range(0, 65535));
        if (kind != EP_NOISE)
        begin
            case ($urandom_range(0, 9))
                0:       p = 0;
                1:       p = 65536;
                default: p = longint'($urandom_range(0, 65536));
            endcase
            s.pedal_a_code = to_code((p * 5 * FULL_SCALE / 4096 + 10 * FULL_SCALE) / 132
                                     + longint'($urandom_range(0, 2)) - 1);
            if (kind != EP_PEDAL_BAD && kind != EP_BOTH_BAD)
                s.pedal_b_code = to_code((p * 3 * FULL_SCALE / 8192 + 3 * FULL_SCALE) / 33
                                         + longint'($urandom_range(0, 2)) - 1);
            if (kind == EP_WHEEL_BAD || kind == EP_BOTH_BAD)
            begin
                s.speed_front = s.speed_front | 16'd64;
                s.speed_rear = s.speed_front >> 1;
            end
            else
                s.speed_rear = s.speed_front
                             - SPEED_W'($urandom_range(0, s.speed_front / 25));
            if ($urandom_range(0, 1))
            begin
                swap = s.speed_front;
                s.speed_front = s.speed_rear;
                s.speed_rear = swap;
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("result %0d: %s is %0d, predicted %0d", results_seen, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_sample(sample_t s, logic known, result_t given);
        int      gap;
        result_t want;
        gap = tx_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, s};
        do @(posedge clk); while (!s_tready);
        want = next_output(s);
        outputs_due.push_back(known ? given : want);
    endtask

    task automatic run_random(int count, bit saturate);
        episode_t kind;
        int       left;
        int       pick;
        sample_t  s;
        left = 0;
        kind = EP_CLEAN;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                pick = $urandom_range(0, 99);
                kind = (pick < 45) ? EP_CLEAN :
                       (pick < 60) ? EP_PEDAL_BAD :
                       (pick < 75) ? EP_WHEEL_BAD :
                       (pick < 85) ? EP_BOTH_BAD : EP_NOISE;
                left = $urandom_range(1, 12);
            end
            // steady wheel mismatch at the longest sample spacing drives elapsed into saturation
            s = make_sample(saturate ? EP_WHEEL_BAD : kind);
            if (saturate)
                s.delta_us = '1;
            send_sample(s, 1'b0, NO_RESULT);
            left--;
        end
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outputs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        case (idx)
            REG_HOLD_TIME:     hold_us = val;
            REG_BRAKE_HIGH:    brake_high = val[LEVEL_W-1:0];
            REG_THROTTLE_HIGH: throttle_high = val[LEVEL_W-1:0];
            default:           start_brake = val[LEVEL_W-1:0];
        endcase
    endtask

    task automatic apply_settings(logic [ELAPSED_W-1:0] hold, logic [LEVEL_W-1:0] bh,
                                  logic [LEVEL_W-1:0] th, logic [LEVEL_W-1:0] sb);
        set_register(REG_HOLD_TIME, hold);
        set_register(REG_BRAKE_HIGH, {7'd0, bh});
        set_register(REG_THROTTLE_HIGH, {7'd0, th});
        set_register(REG_START_BRAKE, {7'd0, sb});
        wr_en <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got = m_tdata[OUT_TDATA_W-2:0];
            if (outputs_due.size() == 0)
            begin
                $display("result %0d arrived with nothing outstanding", results_seen);
                mismatch_count++;
            end
            else
            begin
                want = outputs_due.pop_front();
                if (got.throttle_q16 !== want.throttle_q16)
                    report_mismatch("throttle_q16", got.throttle_q16, want.throttle_q16);
                if (got.phase_now !== want.phase_now)
                    report_mismatch("phase_now", got.phase_now, want.phase_now);
                if (got.pedal_flag !== want.pedal_flag)
                    report_mismatch("pedal_flag", got.pedal_flag, want.pedal_flag);
                if (got.pedal_fault !== want.pedal_fault)
                    report_mismatch("pedal_fault", got.pedal_fault, want.pedal_fault);
                if (got.traction_flag !== want.traction_flag)
                    report_mismatch("traction_flag", got.traction_flag, want.traction_flag);
                if (got.traction_fault !== want.traction_fault)
                    report_mismatch("traction_fault", got.traction_fault, want.traction_fault);
                if (m_tdata[OUT_TDATA_W-1] !== 1'b0)
                    report_mismatch("pad bit", m_tdata[OUT_TDATA_W-1], 0);
            end
        end
    end

    // receiver: random stall before each item, one long hold-off on request
    initial
    begin
        int hold;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            hold = rx_idle_on ? $urandom_range(0, 10) : 0;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 outputs_due.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        wr_en <= 1'b0;
        wr_index <= REG_HOLD_TIME;
        wr_data <= '0;
        mismatch_count = 0;
        results_seen = 0;
        long_hold_req = 1'b0;
        hold_us = HOLD_TIME_RST;
        brake_high = BRAKE_HIGH_RST;
        throttle_high = THROTTLE_HIGH_RST;
        start_brake = START_BRAKE_RST;
        ph_state = PH_WAIT_BRAKE;
        pedal_tmr = '0;
        wheel_tmr = '0;

        // known  result: throttle, phase, pflag, pfault, tflag, tfault
        //        sample: a, b, brake, cockpit, front, rear, delta_us
        dir_table.push_back({1'b1, res(0, PH_WAIT_BRAKE, 0, 0, 0, 0),
                             smp(0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back({1'b1, res(0, PH_WAIT_BRAKE, 0, 0, 0, 0),
                             smp(4095, 4095, 0, 1, 65535, 65535, 65535)});
        // brake one code short of the start level, then just past it
        dir_table.push_back({1'b0, NO_RESULT, smp(0, 0, 2295, 1, 0, 0, 0)});
        dir_table.push_back({1'b0, NO_RESULT, smp(0, 0, 2296, 0, 0, 0, 0)});
        dir_table.push_back({1'b1, res(0, PH_WAIT_COCKPIT, 0, 0, 0, 0),
                             smp(4095, 4095, 4095, 0, 65535, 0, 65535)});
        // switching to run does no checking on that sample
        dir_table.push_back({1'b1, res(0, PH_RUN, 0, 0, 0, 0),
                             smp(4095, 4095, 4095, 1, 65535, 0, 65535)});
        dir_table.push_back({1'b1, res(0, PH_RUN, 1, 0, 0, 0),
                             smp(0, 0, 0, 0, 0, 0, 0)});
        dir_table.push_back({1'b1, res(65536, PH_RUN, 1, 0, 1, 0),
                             smp(4095, 4095, 4095, 0, 65535, 0, 65535)});
        dir_table.push_back({1'b1, res(0, PH_RUN, 1, 1, 1, 0),
                             smp(4095, 4095, 4095, 0, 65535, 0, 65535)});
        dir_table.push_back({1'b1, res(0, PH_RUN, 1, 1, 1, 1),
                             smp(4095, 4095, 4095, 0, 65535, 0, 65535)});
        dir_table.push_back({1'b0, NO_RESULT, smp(1551, 1861, 0, 1, 3000, 3000, 0)});
        dir_table.push_back({1'b0, NO_RESULT, smp(1551, 1861, 0, 1, 0, 0, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(2582, 3099, 4095, 1, 5000, 5000, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(2582, 3099, 0, 1, 5000, 5000, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(2792, 3350, 0, 1, 5000, 5000, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(310, 372, 0, 1, 5000, 5000, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(1551, 0, 0, 1, 5000, 5000, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(1551, 1861, 0, 1, 1000, 1111, 100)});
        dir_table.push_back({1'b0, NO_RESULT, smp(1551, 1861, 0, 1, 1000, 1105, 100)});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (dir_table[i])
            send_sample(dir_table[i].smp, dir_table[i].known, dir_table[i].res);
        run_random(150, 1'b0);
        drain_outputs();

        // lowest thresholds; back-to-back samples into a long receiver hold-off
        apply_settings('0, '0, '0, '0);
        tx_idle_on = 1'b0;
        long_hold_req = 1'b1;
        run_random(100, 1'b0);
        drain_outputs();

        // highest thresholds; wheel timer only latches once elapsed saturates
        apply_settings(ELAPSED_MAX, Q16_ONE, Q16_ONE, Q16_ONE);
        rx_idle_on = 1'b0;
        run_random(135, 1'b1);
        drain_outputs();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(135, 1'b1);
        drain_outputs();

        apply_settings(ELAPSED_W'($urandom_range(0, 300000)), LEVEL_W'($urandom_range(0, 65536)),
                       LEVEL_W'($urandom_range(0, 65536)), LEVEL_W'($urandom_range(0, 65536)));
        run_random(50, 1'b0);
        drain_outputs();
        run_random(50, 1'b0);
        drain_outputs();

        if (mismatch_count == 0 && outputs_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ppm_pkg.sv
rtl/core/ppm_scale.sv
rtl/core/ppm_front.sv
rtl/core/ppm_fifo.sv
rtl/core/ppm_persist.sv
rtl/core/ppm_back.sv
rtl/core/pedal_plausibility_monitor.sv
test/pedal_plausibility_monitor_tb.sv
